// File: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/cpi_pkg.sv
// shared constants, types and the arctangent table of the interpolator
package cpi_pkg;

   localparam int DEF_SAMPLE_WIDTH  = 16;
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int GUARD_BITS        = 4;
   localparam int HEAD_BITS         = 4;
   localparam int ANG_W             = 35;
   localparam int WEIGHT_W          = 17;
   localparam int GAIN_W            = 23;
   localparam int GAIN_FRAC         = 24;

   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic [WEIGHT_W-1:0]     weight_type;

   localparam weight_type      BASE_WEIGHT_RESET = 17'd32768;
   localparam weight_type      ONE_Q16           = 17'h10000;
   localparam logic [GAIN_W-1:0] INV_GAIN_SQ     = 23'd6186701;
   localparam ang_type         ANG_PI            = 35'sd2147483648;
   localparam ang_type         ANG_HALF_PI       = 35'sd1073741824;

   function automatic ang_type atan_val(input int idx);
      ang_type r;
      case (idx)
         0: r = 35'sd536870912;
         1: r = 35'sd316933406;
         2: r = 35'sd167458907;
         3: r = 35'sd85004756;
         4: r = 35'sd42667331;
         5: r = 35'sd21354465;
         6: r = 35'sd10679838;
         7: r = 35'sd5340245;
         8: r = 35'sd2670163;
         9: r = 35'sd1335087;
         10: r = 35'sd667544;
         11: r = 35'sd333772;
         12: r = 35'sd166886;
         13: r = 35'sd83443;
         14: r = 35'sd41722;
         15: r = 35'sd20861;
         16: r = 35'sd10430;
         17: r = 35'sd5215;
         18: r = 35'sd2608;
         19: r = 35'sd1304;
         20: r = 35'sd652;
         21: r = 35'sd326;
         22: r = 35'sd163;
         23: r = 35'sd81;
         24: r = 35'sd41;
         25: r = 35'sd20;
         26: r = 35'sd10;
         27: r = 35'sd5;
         28: r = 35'sd3;
         29: r = 35'sd1;
         30: r = 35'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/complex_polar_interpolator.sv
// throughput: one request per cycle unless a stall holds the pipeline; each cordic iteration has its own pipeline stage
// every stage holds its own valid bit, so empty stages keep filling under a stall
// reset (synchronous, active high) clears all valid bits and sets base_weight to 0.5
// top level: weight register, polar cordic, blend stages, rectangular cordic
`include "assert_macros.svh"

module complex_polar_interpolator #(
   parameter int SAMPLE_WIDTH  = cpi_pkg::DEF_SAMPLE_WIDTH,
   parameter int CORDIC_STAGES = cpi_pkg::DEF_CORDIC_STAGES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_base_re,
   input  logic signed [SAMPLE_WIDTH-1:0] req_base_im,
   input  logic signed [SAMPLE_WIDTH-1:0] req_nb_re,
   input  logic signed [SAMPLE_WIDTH-1:0] req_nb_im,
   input  logic                           req_last_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_re,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_im,
   output logic                           rsp_last_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  cpi_pkg::weight_type            csr_base_weight
);

   localparam int XW = SAMPLE_WIDTH + cpi_pkg::GUARD_BITS + cpi_pkg::HEAD_BITS;

   cpi_pkg::weight_type weight_ff, weight_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= cpi_pkg::BASE_WEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         weight_ff <= csr_base_weight;
      end
   end

   // weights above one act as one
   assign weight_eff = weight_ff[cpi_pkg::WEIGHT_W-1] ? cpi_pkg::ONE_Q16 : weight_ff;

   logic signed [SAMPLE_WIDTH-1:0] pol_x [0:1];
   logic signed [SAMPLE_WIDTH-1:0] pol_y [0:1];
   logic                           pol_in_ready;
   logic                           pol_valid, pol_ready, pol_last;
   logic [XW-1:0]                  pol_mag [0:1];
   cpi_pkg::ang_type               pol_ang [0:1];
   logic                           bl_valid, bl_ready, bl_last;
   logic signed [XW-1:0]           bl_x;
   cpi_pkg::ang_type               bl_z;

   assign pol_x[0]  = req_base_re;
   assign pol_y[0]  = req_base_im;
   assign pol_x[1]  = req_nb_re;
   assign pol_y[1]  = req_nb_im;
   assign req_stall = !pol_in_ready;

   cpi_polar #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_polar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (pol_in_ready),
      .in_x      (pol_x),
      .in_y      (pol_y),
      .in_last   (req_last_in),
      .out_valid (pol_valid),
      .out_ready (pol_ready),
      .out_mag   (pol_mag),
      .out_ang   (pol_ang),
      .out_last  (pol_last)
   );

   cpi_blend #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .weight    (weight_eff),
      .in_valid  (pol_valid),
      .in_ready  (pol_ready),
      .in_mag    (pol_mag),
      .in_ang    (pol_ang),
      .in_last   (pol_last),
      .out_valid (bl_valid),
      .out_ready (bl_ready),
      .out_x     (bl_x),
      .out_z     (bl_z),
      .out_last  (bl_last)
   );

   cpi_rect #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_rect (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bl_valid),
      .in_ready  (bl_ready),
      .in_x      (bl_x),
      .in_z      (bl_z),
      .in_last   (bl_last),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_re    (rsp_out_re),
      .out_im    (rsp_out_im),
      .out_last  (rsp_last_out)
   );

   `ASSERT_NOW(a_no_stall_when_empty_out, clock, reset, !rsp_valid, !req_stall)
   `ASSERT_NOW(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid)
   `ASSERT_NEXT(a_weight_write, clock, reset, csr_valid && csr_ready, weight_ff == $past(csr_base_weight))

endmodule

// File: hdl/cpi_polar.sv
// pipelined vectoring cordic, two lanes, an input fold stage and then one iteration per stage
module cpi_polar #(
   parameter int SAMPLE_WIDTH  = cpi_pkg::DEF_SAMPLE_WIDTH,
   parameter int CORDIC_STAGES = cpi_pkg::DEF_CORDIC_STAGES,
   localparam int XW = SAMPLE_WIDTH + cpi_pkg::GUARD_BITS + cpi_pkg::HEAD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] in_x [0:1],
   input  logic signed [SAMPLE_WIDTH-1:0] in_y [0:1],
   input  logic                           in_last,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [XW-1:0]                  out_mag [0:1],
   output cpi_pkg::ang_type               out_ang [0:1],
   output logic                           out_last
);

   localparam int N = CORDIC_STAGES;

   logic [N:0]   vld_ff;
   logic [N+1:0] rdy;
   logic         last_ff [0:N];

   logic signed [XW-1:0] x_ff    [0:1][0:N];
   logic signed [XW-1:0] y_ff    [0:1][0:N];
   cpi_pkg::ang_type     z_ff    [0:1][0:N];
   logic                 zero_ff [0:1][0:N];

   assign rdy[N+1]  = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N];
   assign out_last  = last_ff[N];

   genvar k, l;
   generate
      for (k = 0; k <= N; k++) begin : g_ctl
         assign rdy[k] = !vld_ff[k] || rdy[k+1];
         if (k == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (reset) begin
                  vld_ff[0] <= 1'b0;
               end else if (rdy[0]) begin
                  vld_ff[0] <= in_valid;
               end
            end
            always_ff @(posedge clock) begin
               if (rdy[0] && in_valid) begin
                  last_ff[0] <= in_last;
               end
            end
         end else begin : g_rest
            always_ff @(posedge clock) begin
               if (reset) begin
                  vld_ff[k] <= 1'b0;
               end else if (rdy[k]) begin
                  vld_ff[k] <= vld_ff[k-1];
               end
            end
            always_ff @(posedge clock) begin
               if (rdy[k] && vld_ff[k-1]) begin
                  last_ff[k] <= last_ff[k-1];
               end
            end
         end
      end

      for (l = 0; l < 2; l++) begin : g_lane
         logic signed [XW-1:0] xs, ys, x_in, y_in;
         cpi_pkg::ang_type     z_in;
         logic                 zero_in;

         // sign extend, add guard bits, fold the left half plane
         always_comb begin
            xs      = {{cpi_pkg::HEAD_BITS{in_x[l][SAMPLE_WIDTH-1]}}, in_x[l],
                       {cpi_pkg::GUARD_BITS{1'b0}}};
            ys      = {{cpi_pkg::HEAD_BITS{in_y[l][SAMPLE_WIDTH-1]}}, in_y[l],
                       {cpi_pkg::GUARD_BITS{1'b0}}};
            zero_in = (in_x[l] == '0) && (in_y[l] == '0);
            if (in_x[l][SAMPLE_WIDTH-1]) begin
               x_in = -xs;
               y_in = -ys;
               z_in = in_y[l][SAMPLE_WIDTH-1] ? -cpi_pkg::ANG_PI : cpi_pkg::ANG_PI;
            end else begin
               x_in = xs;
               y_in = ys;
               z_in = '0;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[0] && in_valid) begin
               x_ff[l][0]    <= x_in;
               y_ff[l][0]    <= y_in;
               z_ff[l][0]    <= z_in;
               zero_ff[l][0] <= zero_in;
            end
         end

         for (k = 1; k <= N; k++) begin : g_iter
            localparam int I = k - 1;
            logic signed [XW-1:0] dx, dy, x_nx_in, y_nx_in;
            cpi_pkg::ang_type     z_nx_in;

            always_comb begin
               dx = y_ff[l][k-1] >>> I;
               dy = x_ff[l][k-1] >>> I;
               if (y_ff[l][k-1] > 0) begin
                  x_nx_in = x_ff[l][k-1] + dx;
                  y_nx_in = y_ff[l][k-1] - dy;
                  z_nx_in = z_ff[l][k-1] + cpi_pkg::atan_val(I);
               end else begin
                  x_nx_in = x_ff[l][k-1] - dx;
                  y_nx_in = y_ff[l][k-1] + dy;
                  z_nx_in = z_ff[l][k-1] - cpi_pkg::atan_val(I);
               end
            end

            always_ff @(posedge clock) begin
               if (rdy[k] && vld_ff[k-1]) begin
                  x_ff[l][k]    <= x_nx_in;
                  y_ff[l][k]    <= y_nx_in;
                  z_ff[l][k]    <= z_nx_in;
                  zero_ff[l][k] <= zero_ff[l][k-1];
               end
            end
         end

         // zero input reads as magnitude 0, angle 0
         assign out_mag[l] = zero_ff[l][N] ? '0 : x_ff[l][N];
         assign out_ang[l] = zero_ff[l][N] ? '0 : z_ff[l][N];
      end
   endgenerate

endmodule

// File: hdl/cpi_blend.sv
// weighted blend of magnitude and angle, gain correction and quadrant fold
module cpi_blend #(
   parameter int SAMPLE_WIDTH = cpi_pkg::DEF_SAMPLE_WIDTH,
   localparam int XW = SAMPLE_WIDTH + cpi_pkg::GUARD_BITS + cpi_pkg::HEAD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cpi_pkg::weight_type  weight,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [XW-1:0]        in_mag [0:1],
   input  cpi_pkg::ang_type     in_ang [0:1],
   input  logic                 in_last,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [XW-1:0] out_x,
   output cpi_pkg::ang_type     out_z,
   output logic                 out_last
);

   localparam int AW  = cpi_pkg::ANG_W;
   localparam int PMW = XW + 1 + cpi_pkg::WEIGHT_W + 1;
   localparam int PAW = AW + 1 + cpi_pkg::WEIGHT_W + 1;
   localparam int GW  = XW + cpi_pkg::GAIN_W;
   localparam int MGW = GW - cpi_pkg::GAIN_FRAC;

   logic [2:0] vld_ff;
   logic [3:0] rdy;
   logic [2:0] last_ff;

   logic signed [PMW-1:0] pm_ff;
   logic [XW-1:0]         mn_ff;
   logic signed [PAW-1:0] pa_ff;
   cpi_pkg::ang_type      an_ff;
   logic [GW-1:0]         g_ff;
   cpi_pkg::ang_type      a_ff;
   logic signed [XW-1:0]  x_ff;
   cpi_pkg::ang_type      z_ff;

   assign rdy[3]    = out_ready;
   assign rdy[2]    = !vld_ff[2] || rdy[3];
   assign rdy[1]    = !vld_ff[1] || rdy[2];
   assign rdy[0]    = !vld_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[2];
   assign out_last  = last_ff[2];
   assign out_x     = x_ff;
   assign out_z     = z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= in_valid;
         end
         if (rdy[1]) begin
            vld_ff[1] <= vld_ff[0];
         end
         if (rdy[2]) begin
            vld_ff[2] <= vld_ff[1];
         end
      end
   end

   // stage 1: weighted differences
   logic signed [XW:0]               dm;
   logic signed [AW:0]               da;
   logic signed [cpi_pkg::WEIGHT_W:0] ws;
   logic signed [PMW-1:0]            pm_in;
   logic signed [PAW-1:0]            pa_in;

   always_comb begin
      ws    = signed'({1'b0, weight});
      dm    = signed'({1'b0, in_mag[0]}) - signed'({1'b0, in_mag[1]});
      da    = (AW+1)'(in_ang[0]) - (AW+1)'(in_ang[1]);
      pm_in = PMW'(dm) * PMW'(ws);
      pa_in = PAW'(da) * PAW'(ws);
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         pm_ff      <= pm_in;
         mn_ff      <= in_mag[1];
         pa_ff      <= pa_in;
         an_ff      <= in_ang[1];
         last_ff[0] <= in_last;
      end
   end

   // stage 2: round the blend, apply inverse gain
   logic signed [PMW-1:0] pm_r, m_full;
   logic signed [PAW-1:0] pa_r, a_full;
   logic [XW-1:0]         m_bl;
   logic [GW-1:0]         g_in;

   always_comb begin
      pm_r   = (pm_ff + PMW'(32768)) >>> 16;
      m_full = pm_r + PMW'(signed'({1'b0, mn_ff}));
      m_bl   = m_full[XW-1:0];
      g_in   = GW'(m_bl) * GW'(cpi_pkg::INV_GAIN_SQ);
      pa_r   = (pa_ff + PAW'(32768)) >>> 16;
      a_full = pa_r + PAW'(an_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[1] && vld_ff[0]) begin
         g_ff       <= g_in;
         a_ff       <= a_full[AW-1:0];
         last_ff[1] <= last_ff[0];
      end
   end

   // stage 3: round the gain product, fold beyond a quarter turn
   logic [GW-1:0]        g_r;
   logic [MGW-1:0]       m_g;
   logic signed [XW-1:0] x_abs, x_in;
   cpi_pkg::ang_type     z_in;

   always_comb begin
      g_r   = g_ff + (GW'(1) << (cpi_pkg::GAIN_FRAC - 1));
      m_g   = g_r[GW-1:cpi_pkg::GAIN_FRAC];
      x_abs = signed'(XW'(m_g));
      if (a_ff > cpi_pkg::ANG_HALF_PI) begin
         z_in = a_ff - cpi_pkg::ANG_PI;
         x_in = -x_abs;
      end else if (a_ff < -cpi_pkg::ANG_HALF_PI) begin
         z_in = a_ff + cpi_pkg::ANG_PI;
         x_in = -x_abs;
      end else begin
         z_in = a_ff;
         x_in = x_abs;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2] && vld_ff[1]) begin
         x_ff       <= x_in;
         z_ff       <= z_in;
         last_ff[2] <= last_ff[1];
      end
   end

endmodule

// File: hdl/cpi_rect.sv
// pipelined rotating cordic with rounding and saturation at the output
module cpi_rect #(
   parameter int SAMPLE_WIDTH  = cpi_pkg::DEF_SAMPLE_WIDTH,
   parameter int CORDIC_STAGES = cpi_pkg::DEF_CORDIC_STAGES,
   localparam int XW = SAMPLE_WIDTH + cpi_pkg::GUARD_BITS + cpi_pkg::HEAD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [XW-1:0]           in_x,
   input  cpi_pkg::ang_type               in_z,
   input  logic                           in_last,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [SAMPLE_WIDTH-1:0] out_re,
   output logic signed [SAMPLE_WIDTH-1:0] out_im,
   output logic                           out_last
);

   localparam int N = CORDIC_STAGES;
   localparam logic signed [XW:0] SAT_HI = (XW+1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [XW:0] SAT_LO = -SAT_HI - (XW+1)'(1);

   logic [N:0]   vld_ff;
   logic [N+1:0] rdy;
   logic         last_ff [0:N];

   logic signed [XW-1:0] x_ff [0:N-1];
   logic signed [XW-1:0] y_ff [0:N-1];
   cpi_pkg::ang_type     z_ff [0:N-1];
   logic signed [SAMPLE_WIDTH-1:0] re_ff, im_ff;

   assign rdy[N+1]  = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N];
   assign out_last  = last_ff[N];
   assign out_re    = re_ff;
   assign out_im    = im_ff;

   genvar k;
   generate
      for (k = 0; k <= N; k++) begin : g_ctl
         logic prev_vld;
         logic prev_last;
         if (k == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_last = in_last;
         end else begin : g_rest
            assign prev_vld  = vld_ff[k-1];
            assign prev_last = last_ff[k-1];
         end
         assign rdy[k] = !vld_ff[k] || rdy[k+1];
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               vld_ff[k] <= prev_vld;
            end
         end
         always_ff @(posedge clock) begin
            if (rdy[k] && prev_vld) begin
               last_ff[k] <= prev_last;
            end
         end
      end

      for (k = 0; k < N; k++) begin : g_iter
         logic signed [XW-1:0] xp, yp, dx, dy, x_in, y_in;
         cpi_pkg::ang_type     zp, z_in;
         logic                 prev_vld;

         if (k == 0) begin : g_first
            assign xp       = in_x;
            assign yp       = '0;
            assign zp       = in_z;
            assign prev_vld = in_valid;
         end else begin : g_rest
            assign xp       = x_ff[k-1];
            assign yp       = y_ff[k-1];
            assign zp       = z_ff[k-1];
            assign prev_vld = vld_ff[k-1];
         end

         always_comb begin
            dx = yp >>> k;
            dy = xp >>> k;
            if (!zp[cpi_pkg::ANG_W-1]) begin
               x_in = xp - dx;
               y_in = yp + dy;
               z_in = zp - cpi_pkg::atan_val(k);
            end else begin
               x_in = xp + dx;
               y_in = yp - dy;
               z_in = zp + cpi_pkg::atan_val(k);
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k] && prev_vld) begin
               x_ff[k] <= x_in;
               y_ff[k] <= y_in;
               z_ff[k] <= z_in;
            end
         end
      end
   endgenerate

   // drop guard bits with round half up, then clamp
   logic signed [XW:0]             re_r, im_r;
   logic signed [SAMPLE_WIDTH-1:0] re_in, im_in;

   always_comb begin
      re_r = ((XW+1)'(x_ff[N-1]) + (XW+1)'(1 << (cpi_pkg::GUARD_BITS - 1)))
             >>> cpi_pkg::GUARD_BITS;
      im_r = ((XW+1)'(y_ff[N-1]) + (XW+1)'(1 << (cpi_pkg::GUARD_BITS - 1)))
             >>> cpi_pkg::GUARD_BITS;
      if (re_r > SAT_HI) begin
         re_in = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (re_r < SAT_LO) begin
         re_in = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         re_in = re_r[SAMPLE_WIDTH-1:0];
      end
      if (im_r > SAT_HI) begin
         im_in = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (im_r < SAT_LO) begin
         im_in = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         im_in = im_r[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[N] && vld_ff[N-1]) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

endmodule

// File: tb/sv/cpi_bin_checker.sv
// checker for the polar interpolator: predicts each bin and compares the responses
module cpi_bin_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic signed [15:0]  req_base_re,
   input  logic signed [15:0]  req_base_im,
   input  logic signed [15:0]  req_nb_re,
   input  logic signed [15:0]  req_nb_im,
   input  logic                req_last_in,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic signed [15:0]  rsp_out_re,
   input  logic signed [15:0]  rsp_out_im,
   input  logic                rsp_last_out,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  cpi_pkg::weight_type csr_base_weight,
   output int                  errors,
   output int                  pending,
   output int                  bins_seen
);

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               last;
   } bin_type;

   localparam longint HALF_TURN = 64'sd2147483648;
   localparam longint QUARTER_TURN = 64'sd1073741824;
   localparam longint ATAN_STEP [16] = '{536870912, 316933406, 167458907, 85004756,
      42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

   bin_type             expected_bins[$];
   cpi_pkg::weight_type blend_weight;

   function automatic void vector_to_polar(input longint xi, input longint yi,
                                           output longint mag, output longint ang);
      longint x, y, z, dx, dy;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         ang = 0;
         return;
      end
      if (x < 0) begin
         z = (y >= 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += ATAN_STEP[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_STEP[i];
         end
      end
      mag = x;
      ang = z;
   endfunction

   function automatic logic signed [15:0] round_saturate(input longint v);
      longint r;
      r = (v + 8) >>> 4;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic bin_type interpolate_bin(input logic signed [15:0] br, bi, nr, ni,
                                               input logic last,
                                               input cpi_pkg::weight_type wt);
      longint mb, ab, mn, an, m, ang, x, y, z, dx, dy, w, bias;
      bin_type b;
      w = (wt > cpi_pkg::ONE_Q16) ? 65536 : longint'(wt);
      bias = 2 * HALF_TURN;
      vector_to_polar(longint'(br) * 16, longint'(bi) * 16, mb, ab);
      vector_to_polar(longint'(nr) * 16, longint'(ni) * 16, mn, an);
      m = (mb * w + mn * (65536 - w) + 32768) >>> 16;
      m = (m * 6186701 + (64'sd1 << 23)) >>> 24;
      ang = (((ab + bias) * w + (an + bias) * (65536 - w) + 32768) >>> 16) - bias;
      x = m;
      y = 0;
      z = ang;
      if (z > QUARTER_TURN) begin
         z -= HALF_TURN; x = -x;
      end else if (z < -QUARTER_TURN) begin
         z += HALF_TURN; x = -x;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_STEP[i];
         end else begin
            x += dx; y -= dy; z += ATAN_STEP[i];
         end
      end
      b.re = round_saturate(x);
      b.im = round_saturate(y);
      b.last = last;
      return b;
   endfunction

   always @(posedge clock) begin
      bin_type want;
      if (reset) begin
         blend_weight <= cpi_pkg::BASE_WEIGHT_RESET;
         expected_bins.delete();
         errors <= 0;
         pending <= 0;
         bins_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) blend_weight <= csr_base_weight;
         if (req_valid && !req_stall)
            expected_bins.push_back(interpolate_bin(req_base_re, req_base_im, req_nb_re,
                                                    req_nb_im, req_last_in, blend_weight));
         if (rsp_valid && !rsp_stall) begin
            bins_seen <= bins_seen + 1;
            if (expected_bins.size() == 0) begin
               $display("%0t: response with none expected: got re %0d im %0d last %0b",
                        $time, rsp_out_re, rsp_out_im, rsp_last_out);
               errors <= errors + 1;
            end else begin
               want = expected_bins.pop_front();
               if (want.re !== rsp_out_re || want.im !== rsp_out_im
                   || want.last !== rsp_last_out) begin
                  $display("%0t: mismatch: expected re %0d im %0d last %0b, got re %0d im %0d last %0b",
                           $time, want.re, want.im, want.last,
                           rsp_out_re, rsp_out_im, rsp_last_out);
                  errors <= errors + 1;
               end
            end
         end
         pending <= expected_bins.size();
      end
   end

endmodule

// File: tb/sv/tb_complex_polar_interpolator.sv
// testbench top: stimulus, weight settings, flow control and verdict for the interpolator
module tb_complex_polar_interpolator;

   localparam int LATENCY = 37;
   localparam int CYCLE_LIMIT = 300000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic signed [15:0]  req_base_re, req_base_im, req_nb_re, req_nb_im;
   logic                req_last_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic signed [15:0]  rsp_out_re, rsp_out_im;
   logic                rsp_last_out;
   logic                csr_valid;
   logic                csr_ready;
   cpi_pkg::weight_type csr_base_weight;
   int                  errors, pending, bins_seen;
   int                  cycles;
   bit                  quiet;
   bit                  long_hold;
   int                  weights_used;

   complex_polar_interpolator dut (.*);

   cpi_bin_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_complex_polar_interpolator: errors");
         $finish;
      end
   end

   // response side flow control
   initial begin
      int n;
      rsp_stall = 0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (200) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_bin(input logic signed [15:0] br, bi, nr, ni, input logic last,
                           input bit no_gap);
      if (!no_gap && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1;
      req_base_re <= br;
      req_base_im <= bi;
      req_nb_re <= nr;
      req_nb_im <= ni;
      req_last_in <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic set_weight(input cpi_pkg::weight_type w);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_valid <= 1;
      csr_base_weight <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      weights_used++;
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(0, 15) - 8);
         3: return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_bins(input int count, input bit no_gap);
      for (int i = 0; i < count; i++)
         send_bin(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                  1'($urandom_range(0, 1)), no_gap);
   endtask

   initial begin
      cpi_pkg::weight_type phase_weights[6];
      req_valid = 0;
      req_base_re = 0;
      req_base_im = 0;
      req_nb_re = 0;
      req_nb_im = 0;
      req_last_in = 0;
      csr_valid = 0;
      csr_base_weight = 0;
      cycles = 0;
      quiet = 0;
      long_hold = 0;
      weights_used = 0;
      @(negedge reset);
      @(posedge clock);

      // directed bins at the reset weight
      send_bin(0, 0, 0, 0, 0, 0);
      send_bin(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1, 0);
      send_bin(16'sh8000, 0, 16'sh8000, 16'sh7fff, 0, 0);
      send_bin(16'sh8000, -1, -1, -1, 1, 0);
      send_bin(-100, 1, 0, 100, 0, 0);
      send_bin(-100, -1, 0, -100, 1, 0);
      send_bin(-100, 1, -100, -1, 0, 0);
      send_bin(16'sh7fff, 0, 0, 16'sh7fff, 1, 0);
      send_bin(0, 16'sh8000, 16'sh7fff, 0, 0, 0);
      send_bin(1, 0, 0, 0, 1, 0);
      send_bin(0, 0, -1, 0, 0, 0);
      send_bin(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 1, 0);

      phase_weights = '{17'h10000, 17'd0, 17'h1ffff, 17'd1, 17'hffff, 17'd0};
      phase_weights[5] = 17'($urandom_range(0, 65536));
      foreach (phase_weights[p]) begin
         set_weight(phase_weights[p]);
         send_bin(-100, 1, 0, 100, 0, 0);
         send_bin(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1, 0);
         if (p == 1) begin
            long_hold = 1;
            random_bins(80, 1);
         end else begin
            random_bins(45, 0);
         end
      end

      set_weight(17'd32768);
      quiet = 1;
      random_bins(50, 1);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d bins over %0d weight settings incl. 0, 1.0 and above one,",
               bins_seen, weights_used + 1);
      $display("with edge and left half plane samples, random stalls and a long output hold");
      if (errors == 0)
         $display("tb_complex_polar_interpolator: clean");
      else
         $display("tb_complex_polar_interpolator: errors");
      $finish;
   end

endmodule
